// ===== rtl/rts_pkg.sv =====
// Shared types, constants and helpers for the rule termination sieve.
`timescale 1ns / 1ps
package rts_pkg;

  localparam int MAX_RULES      = 32;
  localparam int MAX_BOOLEANS   = 32;
  localparam int MAX_NUMERICALS = 32;
  localparam int RULE_AW        = 5;
  localparam int CNT_W          = 6;
  localparam int MASK_W         = 32;

  // Configuration register indexes
  localparam logic [1:0] CFG_RULE_COUNT = 2'd0;
  localparam logic [1:0] CFG_BOOL_COUNT = 2'd1;
  localparam logic [1:0] CFG_NUM_COUNT  = 2'd2;

  // Item function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_RUN  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAND,
    ST_LATCH,
    ST_SWEEP,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  // One stored rule profile
  typedef struct packed {
    logic [MASK_W-1:0] to_true;
    logic [MASK_W-1:0] to_unset;
    logic [MASK_W-1:0] pos_cond;
    logic [MASK_W-1:0] neg_cond;
    logic [MASK_W-1:0] greater_cond;
    logic [MASK_W-1:0] zero_cond;
    logic [MASK_W-1:0] decrease;
    logic [MASK_W-1:0] up;
  } rule_row_t;

  // Saturate a count at its maximum
  function automatic logic [CNT_W-1:0] sat_count(logic [CNT_W-1:0] v, logic [CNT_W-1:0] max);
    return (v > max) ? max : v;
  endfunction

  // Mask of the low n bits, n up to MASK_W
  function automatic logic [MASK_W-1:0] low_mask(logic [CNT_W-1:0] n);
    logic [MASK_W:0] m;
    m = ({{MASK_W{1'b0}}, 1'b1} << n) - {{MASK_W{1'b0}}, 1'b1};
    return m[MASK_W-1:0];
  endfunction

endpackage

// ===== rtl/rts_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module rts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rule_termination_sieve.sv =====
// Top level of the rule termination sieve: rule store and scan sequencer.
// A load item writes the rule store when taken; a run checks each candidate
//   in CAND, LATCH, SWEEP and DECIDE, repeated over the scan passes, then EMIT.
// Throughput: load items one per cycle; busy holds new items off during a run,
//   set by the opponent sweep over the single read port of the rule store.
// Reset: synchronous, clears the state and the count registers; the rule
//   store is undefined until loaded. The receiver cannot stall results.
`timescale 1ns / 1ps
module rule_termination_sieve (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [rts_pkg::CNT_W-1:0]   cfg_data,
  input  logic                        func,
  input  logic [4:0]                  rule_index,
  input  logic [31:0]                 bool_pos_cond,
  input  logic [31:0]                 bool_neg_cond,
  input  logic [31:0]                 bool_pos_eff,
  input  logic [31:0]                 bool_neg_eff,
  input  logic [31:0]                 num_greater_cond,
  input  logic [31:0]                 num_zero_cond,
  input  logic [31:0]                 num_decrease,
  input  logic [31:0]                 num_up_or_free,
  output logic                        done,
  output logic [31:0]                 remaining_mask,
  output logic [31:0]                 marked_bool_mask,
  output logic [31:0]                 marked_num_mask
);
  import rts_pkg::*;

  state_t state, state_next;
  logic [CNT_W-1:0] rule_count, boolean_count, numerical_count;
  logic [CNT_W-1:0] nr, nb, nn;
  logic [CNT_W-1:0] r, r_next;
  logic [RULE_AW-1:0] o, o_next;
  logic [MASK_W-1:0] rem, rem_next, mb, mb_next, mn, mn_next;
  logic [MASK_W-1:0] cnt_num, cnt_num_next, cnt_tf, cnt_tf_next, cnt_tt, cnt_tt_next;
  rule_row_t cur, cur_next, wrow, rrow;
  logic [RULE_AW-1:0] raddr;
  logic accept, load_we, disc, opp;
  logic [MASK_W-1:0] free_num, free_bool, hit_num, hit_bool;
  logic [CNT_W-1:0] last_o;

  assign accept  = start && !busy;
  assign load_we = accept && (func == FUNC_LOAD);
  assign busy    = (state != ST_IDLE);
  assign done    = (state == ST_EMIT);
  assign remaining_mask   = rem;
  assign marked_bool_mask = mb;
  assign marked_num_mask  = mn;

  assign nr = sat_count(rule_count, CNT_W'(MAX_RULES));
  assign nb = sat_count(boolean_count, CNT_W'(MAX_BOOLEANS));
  assign nn = sat_count(numerical_count, CNT_W'(MAX_NUMERICALS));
  assign last_o = nr - CNT_W'(1);

  // Build the stored profile from a load item
  always_comb begin
    wrow.to_true      = bool_neg_cond & bool_pos_eff;
    wrow.to_unset     = bool_pos_cond & bool_neg_eff;
    wrow.pos_cond     = bool_pos_cond;
    wrow.neg_cond     = bool_neg_cond;
    wrow.greater_cond = num_greater_cond;
    wrow.zero_cond    = num_zero_cond;
    wrow.decrease     = num_decrease;
    wrow.up           = num_up_or_free;
  end

  rts_ram #(.WIDTH($bits(rule_row_t)), .DEPTH(MAX_RULES)) u_store (
    .clk   (clk),
    .we    (load_we),
    .waddr (rule_index),
    .wdata (wrow),
    .raddr (raddr),
    .rdata (rrow)
  );

  // Opposition test of the swept rule against the candidate
  assign disc = |((cur.pos_cond & rrow.neg_cond & mb) | (cur.neg_cond & rrow.pos_cond & mb) |
                  (cur.greater_cond & rrow.zero_cond & mn) |
                  (cur.zero_cond & rrow.greater_cond & mn));
  assign opp  = ({1'b0, o} != r) && rem[o] && !disc;

  // Uncountered features of the candidate, lowest one wins
  assign free_num  = cur.decrease & ~cnt_num & low_mask(nn);
  assign free_bool = ((cur.to_true & ~cnt_tf) | (~cur.to_true & cur.to_unset & ~cnt_tt))
                     & low_mask(nb);
  assign hit_num   = free_num & (~free_num + MASK_W'(1));
  assign hit_bool  = free_bool & (~free_bool + MASK_W'(1));

  // Sequencer: next state and datapath
  always_comb begin
    state_next   = state;
    r_next       = r;
    o_next       = o;
    rem_next     = rem;
    mb_next      = mb;
    mn_next      = mn;
    cnt_num_next = cnt_num;
    cnt_tf_next  = cnt_tf;
    cnt_tt_next  = cnt_tt;
    cur_next     = cur;
    raddr        = o;
    unique case (state)
      ST_IDLE: begin
        if (accept && (func == FUNC_RUN)) begin
          rem_next   = low_mask(nr);
          mb_next    = '0;
          mn_next    = '0;
          r_next     = '0;
          state_next = ST_CAND;
        end
      end
      ST_CAND: begin
        raddr = r[RULE_AW-1:0];
        if (r >= nr) begin
          state_next = ST_EMIT;
        end else if (!rem[r[RULE_AW-1:0]]) begin
          r_next = r + CNT_W'(1);
        end else begin
          state_next = ST_LATCH;
        end
      end
      ST_LATCH: begin
        cur_next     = rrow;
        cnt_num_next = '0;
        cnt_tf_next  = '0;
        cnt_tt_next  = '0;
        o_next       = '0;
        raddr        = '0;
        state_next   = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (opp) begin
          cnt_num_next = cnt_num | rrow.up;
          cnt_tf_next  = cnt_tf | rrow.to_unset;
          cnt_tt_next  = cnt_tt | rrow.to_true;
        end
        if ({1'b0, o} == last_o) begin
          state_next = ST_DECIDE;
        end else begin
          o_next = o + RULE_AW'(1);
          raddr  = o + RULE_AW'(1);
        end
      end
      ST_DECIDE: begin
        state_next = ST_CAND;
        if (free_num != '0) begin
          rem_next = rem & ~(MASK_W'(1) << r[RULE_AW-1:0]);
          mn_next  = mn | hit_num;
          r_next   = '0;
        end else if (free_bool != '0) begin
          rem_next = rem & ~(MASK_W'(1) << r[RULE_AW-1:0]);
          mb_next  = mb | hit_bool;
          r_next   = '0;
        end else begin
          r_next = r + CNT_W'(1);
        end
      end
      ST_EMIT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold state and scan registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    r       <= r_next;
    o       <= o_next;
    rem     <= rem_next;
    mb      <= mb_next;
    mn      <= mn_next;
    cnt_num <= cnt_num_next;
    cnt_tf  <= cnt_tf_next;
    cnt_tt  <= cnt_tt_next;
    cur     <= cur_next;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rule_count      <= '0;
      boolean_count   <= '0;
      numerical_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RULE_COUNT: rule_count      <= cfg_data;
        CFG_BOOL_COUNT: boolean_count   <= cfg_data;
        CFG_NUM_COUNT:  numerical_count <= cfg_data;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_run_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (func == FUNC_RUN)) |=> busy)
    else $error("run transfer did not start the scan");
  a_done_then_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("sequencer stayed busy after emit");
  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ((remaining_mask & ~low_mask(nr)) == '0))
    else $error("remaining rule beyond rule count");
  a_marks_in_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (((marked_bool_mask & ~low_mask(nb)) == '0) &&
              ((marked_num_mask & ~low_mask(nn)) == '0)))
    else $error("marked feature beyond feature count");
`endif

endmodule

// ===== tb/rule_termination_sieve_tb.sv =====
// Testbench for the rule termination sieve: random rule loads and sieve runs checked by a scoreboard.
`timescale 1ns / 1ps
module rule_termination_sieve_tb;
  import rts_pkg::*;

  // Register index past the end of the register list
  localparam logic [1:0] CFG_SPARE = 2'd3;

  typedef struct {
    logic        func;
    logic [4:0]  idx;
    logic [31:0] pc, nc, pe, ne, gc, zc, dec, up;
  } item_t;

  typedef struct {
    logic [31:0] rem, mb, mn;
  } sieve_out_t;

  // Rule store mirror, sieve predictor and queue of pending sieve results
  class sieve_scoreboard;
    logic [31:0] to_true[MAX_RULES], to_unset[MAX_RULES];
    logic [31:0] pos_c[MAX_RULES], neg_c[MAX_RULES];
    logic [31:0] gt_c[MAX_RULES], zero_c[MAX_RULES];
    logic [31:0] decr[MAX_RULES], upf[MAX_RULES];
    int unsigned rule_cnt, bool_cnt, num_cnt;
    sieve_out_t pending_q[$];
    int errors;

    function void set_reg(logic [1:0] index, logic [5:0] value);
      case (index)
        CFG_RULE_COUNT: rule_cnt = value;
        CFG_BOOL_COUNT: bool_cnt = value;
        CFG_NUM_COUNT:  num_cnt = value;
        default: ;
      endcase
    endfunction

    function bit discounted(int r, int o, logic [31:0] mb, logic [31:0] mn);
      return (pos_c[r] & neg_c[o] & mb) != 0 || (neg_c[r] & pos_c[o] & mb) != 0 ||
             (gt_c[r] & zero_c[o] & mn) != 0 || (zero_c[r] & gt_c[o] & mn) != 0;
    endfunction

    // kind 0: numerical, 1: to-false opponents, 2: to-true opponents
    function bit countered(int r, int kind, int p, logic [31:0] rem, int nr,
                           logic [31:0] mb, logic [31:0] mn);
      logic [31:0] m;
      for (int o = 0; o < nr; o++) begin
        if (o == r || !rem[o]) continue;
        m = (kind == 0) ? upf[o] : ((kind == 1) ? to_unset[o] : to_true[o]);
        if (m[p] && !discounted(r, o, mb, mn)) return 1;
      end
      return 0;
    endfunction

    function void note_item(item_t it);
      int nr, nb, nn;
      logic [31:0] rem, mb, mn;
      bit elim;
      sieve_out_t res;
      if (it.func == FUNC_LOAD) begin
        to_true[it.idx] = it.nc & it.pe;
        to_unset[it.idx] = it.pc & it.ne;
        pos_c[it.idx] = it.pc;
        neg_c[it.idx] = it.nc;
        gt_c[it.idx] = it.gc;
        zero_c[it.idx] = it.zc;
        decr[it.idx] = it.dec;
        upf[it.idx] = it.up;
        return;
      end
      nr = (rule_cnt > MAX_RULES) ? MAX_RULES : rule_cnt;
      nb = (bool_cnt > MAX_BOOLEANS) ? MAX_BOOLEANS : bool_cnt;
      nn = (num_cnt > MAX_NUMERICALS) ? MAX_NUMERICALS : num_cnt;
      rem = (nr == 32) ? 32'hFFFF_FFFF : ((32'h1 << nr) - 32'h1);
      mb = 0;
      mn = 0;
      do begin
        elim = 0;
        for (int r = 0; r < nr && !elim; r++) begin
          if (!rem[r]) continue;
          for (int p = 0; p < nn && !elim; p++) begin
            if (!decr[r][p]) continue;
            if (!countered(r, 0, p, rem, nr, mb, mn)) begin
              rem[r] = 1'b0;
              mn[p] = 1'b1;
              elim = 1;
            end
          end
          for (int p = 0; p < nb && !elim; p++) begin
            if (!to_true[r][p] && !to_unset[r][p]) continue;
            if (!countered(r, to_true[r][p] ? 1 : 2, p, rem, nr, mb, mn)) begin
              rem[r] = 1'b0;
              mb[p] = 1'b1;
              elim = 1;
            end
          end
        end
      end while (elim);
      res.rem = rem;
      res.mb = mb;
      res.mn = mn;
      pending_q = {pending_q, res};
    endfunction

    function void check(logic [31:0] rem, logic [31:0] mb, logic [31:0] mn);
      sieve_out_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result rem=%h mb=%h mn=%h", $time, rem, mb, mn);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (rem !== e.rem) begin
        $display("%0t: remaining_mask expected %h actual %h", $time, e.rem, rem);
        errors++;
      end
      if (mb !== e.mb) begin
        $display("%0t: marked_bool_mask expected %h actual %h", $time, e.mb, mb);
        errors++;
      end
      if (mn !== e.mn) begin
        $display("%0t: marked_num_mask expected %h actual %h", $time, e.mn, mn);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst, start, busy, cfg_we, func, done;
  logic [1:0] cfg_index;
  logic [CNT_W-1:0] cfg_data;
  logic [4:0] rule_index;
  logic [31:0] bool_pos_cond, bool_neg_cond, bool_pos_eff, bool_neg_eff;
  logic [31:0] num_greater_cond, num_zero_cond, num_decrease, num_up_or_free;
  logic [31:0] remaining_mask, marked_bool_mask, marked_num_mask;

  sieve_scoreboard sb;
  bit idling;

  rule_termination_sieve dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .func(func), .rule_index(rule_index),
    .bool_pos_cond(bool_pos_cond), .bool_neg_cond(bool_neg_cond),
    .bool_pos_eff(bool_pos_eff), .bool_neg_eff(bool_neg_eff),
    .num_greater_cond(num_greater_cond), .num_zero_cond(num_zero_cond),
    .num_decrease(num_decrease), .num_up_or_free(num_up_or_free),
    .done(done), .remaining_mask(remaining_mask),
    .marked_bool_mask(marked_bool_mask), .marked_num_mask(marked_num_mask)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop on a hung run
  initial begin
    #300ms;
    $display("tb: failure");
    $finish;
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (!rst && done) sb.check(remaining_mask, marked_bool_mask, marked_num_mask);
  end

  // Random mask; higher density means fewer set bits
  function automatic logic [31:0] rand_mask(int density);
    logic [31:0] m;
    case ($urandom_range(0, 9))
      0: m = 32'h0;
      1: m = 32'hFFFF_FFFF;
      default: begin
        m = $urandom;
        for (int i = 1; i < density; i++) m &= $urandom;
      end
    endcase
    return m;
  endfunction

  function automatic item_t rand_load(int density);
    item_t it;
    it.func = FUNC_LOAD;
    it.idx = 5'($urandom_range(0, 31));
    it.pc = rand_mask(density);
    it.nc = rand_mask(density);
    it.pe = rand_mask(density);
    it.ne = rand_mask(density);
    it.gc = rand_mask(density);
    it.zc = rand_mask(density);
    it.dec = rand_mask(density);
    it.up = rand_mask(density);
    return it;
  endfunction

  function automatic item_t run_item();
    item_t it;
    it = rand_load(1);
    it.func = FUNC_RUN;
    return it;
  endfunction

  task automatic write_reg(logic [1:0] index, logic [5:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_data = value;
    @(posedge clk);
    sb.set_reg(index, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Present one item and hold it until transferred, then maybe idle
  task automatic send_item(item_t it);
    @(negedge clk);
    start = 1'b1;
    func = it.func;
    rule_index = it.idx;
    bool_pos_cond = it.pc;
    bool_neg_cond = it.nc;
    bool_pos_eff = it.pe;
    bool_neg_eff = it.ne;
    num_greater_cond = it.gc;
    num_zero_cond = it.zc;
    num_decrease = it.dec;
    num_up_or_free = it.up;
    while (busy) @(negedge clk);
    @(posedge clk);
    sb.note_item(it);
    if (idling && $urandom_range(0, 99) < 18) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
  endtask

  // Drop start and drain every pending result
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    item_t it;
    int rc, bc, nc, density, n_items;
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_RULE_COUNT;
    cfg_data = '0;
    func = FUNC_LOAD;
    rule_index = '0;
    bool_pos_cond = '0;
    bool_neg_cond = '0;
    bool_pos_eff = '0;
    bool_neg_eff = '0;
    num_greater_cond = '0;
    num_zero_cond = '0;
    num_decrease = '0;
    num_up_or_free = '0;
    idling = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Zero rules: result is all zero
    it = run_item();
    send_item(it);
    drain();

    // Fill every slot so no run reads an unwritten rule; first and last rows extreme
    for (int i = 0; i < MAX_RULES; i++) begin
      it = rand_load(3);
      it.idx = 5'(i);
      if (i == 0) begin
        it.pc = '1; it.nc = '1; it.pe = '1; it.ne = '1;
        it.gc = '1; it.zc = '1; it.dec = '1; it.up = '1;
      end else if (i == 31) begin
        it.pc = '0; it.nc = '0; it.pe = '0; it.ne = '0;
        it.gc = '0; it.zc = '0; it.dec = '0; it.up = '0;
      end
      send_item(it);
    end
    drain();

    // Small set with flips both ways, then saturated counts
    write_reg(CFG_RULE_COUNT, 6'd3);
    write_reg(CFG_BOOL_COUNT, 6'd4);
    write_reg(CFG_NUM_COUNT, 6'd4);
    write_reg(CFG_SPARE, 6'd63);
    send_item(run_item());
    drain();

    for (int ph = 0; ph < 42; ph++) begin
      idling = (ph != 5);
      density = 2;
      n_items = 45;
      case (ph)
        0: begin rc = 32; bc = 32; nc = 32; density = 4; n_items = 20; end
        1: begin rc = 63; bc = 63; nc = 63; density = 4; n_items = 20; end
        2: begin rc = 0; bc = 0; nc = 0; end
        3: begin rc = 1; bc = 32; nc = 32; end
        4: begin rc = 2; bc = 1; nc = 1; end
        default: begin
          rc = $urandom_range(2, 7);
          bc = $urandom_range(0, 8);
          nc = $urandom_range(0, 8);
          density = $urandom_range(1, 3);
        end
      endcase
      write_reg(CFG_RULE_COUNT, 6'(rc));
      write_reg(CFG_BOOL_COUNT, 6'(bc));
      write_reg(CFG_NUM_COUNT, 6'(nc));
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 6) == 0) it = run_item();
        else begin
          it = rand_load(density);
          // Keep loads mostly on the active rows so runs see fresh profiles
          if (rc > 0 && rc < 32 && $urandom_range(0, 3) != 0)
            it.idx = 5'($urandom_range(0, rc - 1));
        end
        send_item(it);
      end
      send_item(run_item());
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rts_pkg.sv
rtl/rts_ram.sv
rtl/rule_termination_sieve.sv
tb/rule_termination_sieve_tb.sv
